@@ sv/rpra_pkg.sv @@
// Shared codes and reset values for the redundant pair role arbiter.
// No dependencies; imported by the top level.
package rpra_pkg;

  // default width of the elapsed-seconds counter
  localparam int TIME_BITS_DEF = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // refresh payload and counter widths
  localparam int REFRESH_W = 32;
  localparam int COUNT_W   = 8;

  typedef logic [2:0] op_t;
  typedef logic [1:0] role_t;
  typedef logic [1:0] alarm_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam op_t OP_TICK          = 3'd0;
  localparam op_t OP_LISTEN_TIMEOUT = 3'd1;
  localparam op_t OP_ACCEPT        = 3'd2;
  localparam op_t OP_SEND_FAIL     = 3'd3;
  localparam op_t OP_REPLY_TIMEOUT = 3'd4;
  localparam op_t OP_RECV_ERROR    = 3'd5;
  localparam op_t OP_REPLY         = 3'd6;

  localparam role_t ROLE_ACTIVE  = 2'd0;
  localparam role_t ROLE_STANDBY = 2'd1;
  localparam role_t ROLE_PENDING = 2'd2;
  localparam role_t ROLE_UNUSED  = 2'd3;

  localparam alarm_t ALARM_NONE    = 2'd0;
  localparam alarm_t ALARM_DEAD    = 2'd1;
  localparam alarm_t ALARM_RESUMED = 2'd2;

  localparam cfg_idx_t REG_CONFIGURED_ROLE = 3'd0;
  localparam cfg_idx_t REG_INITIAL_ROLE    = 3'd1;
  localparam cfg_idx_t REG_INITIAL_ALIVE   = 3'd2;
  localparam cfg_idx_t REG_IGNORE_WINDOW   = 3'd3;
  localparam cfg_idx_t REG_DEAD_LIMIT      = 3'd4;
  localparam cfg_idx_t REG_FAIL_LIMIT      = 3'd5;

  localparam logic [15:0]        IGNORE_WINDOW_RST = 16'd120;
  localparam logic [COUNT_W-1:0] DEAD_LIMIT_RST    = 8'd18;
  localparam logic [COUNT_W-1:0] FAIL_LIMIT_RST    = 8'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX         = 8'd255;

endpackage

@@ sv/redundant_pair_role_arbiter.sv @@
// Role arbiter for one board of a redundant pair: active, standby or pending.
// Depends on rpra_pkg for event, role, alarm and register codes.
//
// Usage:
//   Event words enter on the s_ channel: s_tuser carries the event code,
//   s_tdata the refresh counter, the peer's reported role and liveness.
//   Every event word yields exactly one result word on the m_ channel with
//   the role after the event, a role-change flag, the watchdog alarm, the
//   peer-down notice, the drop-link request and the local liveness flag.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data
//   while no event is in flight; writing initial_role or initial_alive also
//   loads the live role or liveness flag at once.
//   The accepted word sits in the input register, then the decision logic
//   and state update feed the result register. One event per cycle is
//   sustained while m_tready is high; the limit is the single state update
//   done per cycle in the decision stage.
//   Reset (rst, synchronous) empties both stages, restores register defaults
//   and clears the watchdog and failure counters; no clearing pass is needed.
//   When m_tready is low the result word holds, the input register keeps one
//   more word, and s_tready drops only once both are occupied.
module redundant_pair_role_arbiter #(
  parameter int TIME_BITS = rpra_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // event input
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // refresh_count[31:0], peer_role[33:32], peer_alive[34]
  input  rpra_pkg::op_t        s_tuser,   // op[2:0]
  // result output
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // role[1:0], role_changed[2], alarm[4:3],
                                          // peer_down_notice[5], drop_link[6], local_alive[7]
  // configuration writes
  input  logic                 cfg_we,
  input  rpra_pkg::cfg_idx_t   cfg_index,
  input  rpra_pkg::cfg_data_t  cfg_data
);
  import rpra_pkg::*;

  typedef logic [TIME_BITS-1:0] time_t;

  // configuration registers
  logic                 configured_role;
  role_t                initial_role;
  logic                 initial_alive;
  logic [15:0]          ignore_window;
  logic [COUNT_W-1:0]   dead_limit;
  logic [COUNT_W-1:0]   fail_limit;

  // arbiter state
  role_t                current_role, role_next;
  logic                 alive_flag, alive_next;
  logic                 update_flag, update_next;
  logic [REFRESH_W-1:0] last_refresh, last_next;
  logic [COUNT_W-1:0]   miss_count, miss_next;
  time_t                first_miss_time, first_next;
  time_t                elapsed_seconds, elapsed_next;
  logic [COUNT_W-1:0]   fail_count, fail_next;
  logic                 peer_down_sent, peer_down_next;

  // input register
  logic                 s1_valid;
  op_t                  s1_op;
  logic [REFRESH_W-1:0] s1_refresh;
  role_t                s1_peer_role;
  logic                 s1_peer_alive;

  logic advance, proc;

  assign advance  = !m_tvalid || m_tready;
  assign proc     = s1_valid && advance;
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_op         <= s_tuser;
      s1_refresh    <= s_tdata[31:0];
      s1_peer_role  <= s_tdata[33:32];
      s1_peer_alive <= s_tdata[34];
    end
  end

  // ---------------------------------------------------------------------------
  // liveness watchdog
  // ---------------------------------------------------------------------------
  logic               past_window;
  logic               wd_run;
  logic [COUNT_W-1:0] miss_inc;
  time_t              wd_first;
  time_t              quiet_span;
  logic               dead_hit;
  logic               wd_alive, wd_update;
  logic [COUNT_W-1:0] wd_miss;
  alarm_t             wd_alarm;

  assign past_window = elapsed_seconds >= time_t'(ignore_window);
  assign miss_inc    = (miss_count == COUNT_MAX) ? miss_count : miss_count + 1'b1;
  // first miss of a run restarts the quiet timer
  assign wd_first    = (miss_inc == COUNT_W'(1)) ? elapsed_seconds : first_miss_time;
  assign quiet_span  = elapsed_seconds - wd_first;
  assign dead_hit    = quiet_span > time_t'(dead_limit);

  always_comb begin
    wd_alive  = alive_flag;
    wd_update = update_flag;
    wd_alarm  = ALARM_NONE;
    if (s1_refresh != last_refresh) begin
      wd_miss = '0;
      if (!alive_flag) begin
        wd_alarm  = ALARM_RESUMED;
        wd_alive  = 1'b1;
        wd_update = 1'b1;
      end
    end else begin
      wd_miss = dead_hit ? '0 : miss_inc;
      if (dead_hit && alive_flag) begin
        wd_alarm  = ALARM_DEAD;
        wd_alive  = 1'b0;
        wd_update = 1'b1;
      end
    end
  end

  always_comb begin
    case (s1_op)
      OP_LISTEN_TIMEOUT, OP_ACCEPT: wd_run = past_window;
      OP_REPLY:                     wd_run = past_window && (current_role != ROLE_PENDING);
      default:                      wd_run = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // event decision
  // ---------------------------------------------------------------------------
  logic               [COUNT_W-1:0] fail_inc;
  logic               fail_over;
  role_t              cfg_role;
  alarm_t             alarm;
  logic               notice, drop;

  assign fail_inc  = (fail_count == COUNT_MAX) ? fail_count : fail_count + 1'b1;
  assign fail_over = fail_inc > fail_limit;
  assign cfg_role  = configured_role ? ROLE_STANDBY : ROLE_ACTIVE;

  always_comb begin
    role_next      = current_role;
    alive_next     = wd_run ? wd_alive : alive_flag;
    update_next    = wd_run ? wd_update : update_flag;
    last_next      = wd_run ? s1_refresh : last_refresh;
    miss_next      = wd_run ? wd_miss : miss_count;
    first_next     = (wd_run && s1_refresh == last_refresh) ? wd_first : first_miss_time;
    alarm          = wd_run ? wd_alarm : ALARM_NONE;
    elapsed_next   = elapsed_seconds;
    fail_next      = fail_count;
    peer_down_next = peer_down_sent;
    notice         = 1'b0;
    drop           = 1'b0;
    case (s1_op)
      OP_TICK: begin
        if (elapsed_seconds != '1) elapsed_next = elapsed_seconds + time_t'(1);
      end
      OP_LISTEN_TIMEOUT: begin
        role_next = ROLE_ACTIVE;
        if (!peer_down_sent) begin
          peer_down_next = 1'b1;
          notice         = 1'b1;
        end
      end
      OP_ACCEPT: begin
        peer_down_next = 1'b0;
        update_next    = 1'b1;
        fail_next      = '0;
      end
      OP_SEND_FAIL: begin
        role_next = ROLE_ACTIVE;
        drop      = 1'b1;
      end
      OP_REPLY_TIMEOUT: begin
        fail_next = fail_inc;
        if (fail_over) begin
          role_next = ROLE_ACTIVE;
          drop      = 1'b1;
        end
      end
      OP_RECV_ERROR: begin
        fail_next = fail_inc;
        if (fail_over) role_next = ROLE_ACTIVE;
        drop = 1'b1;
      end
      OP_REPLY: begin
        fail_next = '0;
        if (current_role == ROLE_PENDING) begin
          role_next = (s1_peer_role == ROLE_ACTIVE) ? ROLE_STANDBY : ROLE_ACTIVE;
        end else if (past_window) begin
          // role clash rules use liveness as left by the watchdog
          if (alive_next) begin
            if (update_next) begin
              update_next = 1'b0;
              if (!s1_peer_alive) role_next = ROLE_ACTIVE;
            end else if (s1_peer_role == current_role) begin
              role_next = s1_peer_alive ? cfg_role : ROLE_ACTIVE;
            end
          end else begin
            if (update_next) begin
              update_next = 1'b0;
              if (s1_peer_alive) role_next = ROLE_STANDBY;
            end else if (s1_peer_role == current_role) begin
              role_next = s1_peer_alive ? ROLE_STANDBY : cfg_role;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // state and configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      configured_role <= 1'b0;
      initial_role    <= ROLE_ACTIVE;
      initial_alive   <= 1'b0;
      ignore_window   <= IGNORE_WINDOW_RST;
      dead_limit      <= DEAD_LIMIT_RST;
      fail_limit      <= FAIL_LIMIT_RST;
      current_role    <= ROLE_ACTIVE;
      alive_flag      <= 1'b0;
      update_flag     <= 1'b0;
      last_refresh    <= '0;
      miss_count      <= '0;
      first_miss_time <= '0;
      elapsed_seconds <= '0;
      fail_count      <= '0;
      peer_down_sent  <= 1'b0;
    end else begin
      if (proc) begin
        current_role    <= role_next;
        alive_flag      <= alive_next;
        update_flag     <= update_next;
        last_refresh    <= last_next;
        miss_count      <= miss_next;
        first_miss_time <= first_next;
        elapsed_seconds <= elapsed_next;
        fail_count      <= fail_next;
        peer_down_sent  <= peer_down_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CONFIGURED_ROLE: configured_role <= cfg_data[0];
          REG_INITIAL_ROLE: begin
            // code three is taken as pending
            if (cfg_data[1:0] == ROLE_UNUSED) begin
              initial_role <= ROLE_PENDING;
              current_role <= ROLE_PENDING;
            end else begin
              initial_role <= cfg_data[1:0];
              current_role <= cfg_data[1:0];
            end
          end
          REG_INITIAL_ALIVE: begin
            initial_alive <= cfg_data[0];
            alive_flag    <= cfg_data[0];
          end
          REG_IGNORE_WINDOW: ignore_window <= cfg_data;
          REG_DEAD_LIMIT:    dead_limit    <= cfg_data[COUNT_W-1:0];
          REG_FAIL_LIMIT:    fail_limit    <= cfg_data[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      m_tdata <= {alive_next, drop, notice, alarm, role_next != current_role, role_next};
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a word waiting in the input register is never lost while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("input register word lost during output stall");

  // a send failure ends active with a drop request unless a configuration write coincides
  a_send_fail: assert property (@(posedge clk) disable iff (rst)
    (proc && s1_op == OP_SEND_FAIL && !cfg_we) |=>
      (m_tvalid && m_tdata[6] && current_role == ROLE_ACTIVE))
    else $error("send failure did not force active role");

  // elapsed time never moves backward
  a_elapsed_mono: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (elapsed_seconds >= $past(elapsed_seconds)))
    else $error("elapsed seconds decreased");

endmodule
